// ===== design/speed_profile_node_cost_core_defines.svh =====
// ----------------------------------------------------------------------------
// Speed profile node cost assertion macros
// Assertion helpers used by the node cost core.
// ----------------------------------------------------------------------------
`ifndef SPEED_PROFILE_NODE_COST_CORE_DEFINES_SVH
`define SPEED_PROFILE_NODE_COST_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SPNC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SPNC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPNC_ASSERT(label, prop, msg)
`define SPNC_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== design/spnc_pkg.sv =====
// ----------------------------------------------------------------------------
// Speed profile node cost package
// Shared types and constants.
// ----------------------------------------------------------------------------
`default_nettype none
package spnc_pkg;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 48;
  localparam logic [CfgIdxW-1:0] REG_GOAL = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_STEP = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MINSPD = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ACCB = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DECB = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MOTW = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SPDW = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_STOPW = 3'd7;
  localparam logic [31:0] HARD_COST = 32'd655360000;
  localparam logic [31:0] SAT = 32'hFFFF_FFFF;
  localparam int SmallAccel = 40;

  typedef struct packed {
    logic [23:0] position;
    logic [15:0] speed;
    logic signed [15:0] accel;
    logic signed [15:0] jerk_value;
    logic [15:0] limit_speed;
    logic at_rest;
    logic [31:0] prior_cost;
  } in_item_t;

  typedef struct packed {
    logic [31:0] stop_cost;
    logic [31:0] limit_cost;
    logic [31:0] accel_cost;
    logic [31:0] jerk_cost_out;
    logic [31:0] sum_cost;
  } out_item_t;

  function automatic logic [31:0] sat32(input logic [47:0] v);
    return (|v[47:32]) ? SAT : v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== design/spnc_if.sv =====
// ----------------------------------------------------------------------------
// Speed profile node cost channels
// Valid/ready channels for node items and cost items.
// ----------------------------------------------------------------------------
`default_nettype none
interface spnc_in_if;
  import spnc_pkg::*;
  logic valid;
  logic ready;
  logic [23:0] position;
  logic [15:0] speed;
  logic signed [15:0] accel;
  logic signed [15:0] jerk_value;
  logic [15:0] limit_speed;
  logic at_rest;
  logic [31:0] prior_cost;
  modport source(output valid, position, speed, accel, jerk_value, limit_speed,
                 at_rest, prior_cost, input ready);
  modport sink(input valid, position, speed, accel, jerk_value, limit_speed,
               at_rest, prior_cost, output ready);
endinterface

interface spnc_out_if;
  logic valid;
  logic ready;
  logic [31:0] stop_cost;
  logic [31:0] limit_cost;
  logic [31:0] accel_cost;
  logic [31:0] jerk_cost_out;
  logic [31:0] sum_cost;
  modport source(output valid, stop_cost, limit_cost, accel_cost, jerk_cost_out,
                 sum_cost, input ready);
  modport sink(input valid, stop_cost, limit_cost, accel_cost, jerk_cost_out,
               sum_cost, output ready);
endinterface
`default_nettype wire

// ===== design/speed_profile_node_cost_core.sv =====
// ----------------------------------------------------------------------------
// Speed profile node cost core
// Computes stopover, speed, acceleration and jerk costs of a graph node and their sum with the prior cost.
// ----------------------------------------------------------------------------
// One node item enters per cycle while the output is not stalled, and its cost
// item leaves through a four-stage pipeline (products, squares, weighting,
// sum); a stall on the output holds every stage and deasserts node.ready.
`default_nettype none
module speed_profile_node_cost_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [spnc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [spnc_pkg::CfgDataW-1:0] cfg_data,
  spnc_in_if.sink  node,
  spnc_out_if.source cost
);
  import spnc_pkg::*;
`include "speed_profile_node_cost_core_defines.svh"

  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_HARD = 2'd1;
  localparam logic [1:0] KIND_BAND = 2'd2;

  logic [23:0] goal_distance;
  logic [15:0] step_length, min_speed, stop_weight;
  logic [31:0] accel_bounds, decel_bounds;
  logic [47:0] motion_weights, speed_weights;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_distance <= '0; step_length <= 16'd256; min_speed <= '0;
      accel_bounds <= '0; decel_bounds <= '0; motion_weights <= '0;
      speed_weights <= '0; stop_weight <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GOAL:   goal_distance <= cfg_data[23:0];
        REG_STEP:   step_length <= cfg_data[15:0];
        REG_MINSPD: min_speed <= cfg_data[15:0];
        REG_ACCB:   accel_bounds <= cfg_data[31:0];
        REG_DECB:   decel_bounds <= cfg_data[31:0];
        REG_MOTW:   motion_weights <= cfg_data;
        REG_SPDW:   speed_weights <= cfg_data;
        REG_STOPW:  stop_weight <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [3:0] vld;
  logic adv;
  assign adv = !vld[3] || cost.ready;
  assign node.ready = adv;
  wire logic acc_in = node.valid && node.ready;

  // stage 1: stop product, speed products, squares of speed/limit, accel diff
  logic [39:0] s1_stop;
  logic [33:0] s1_q18;
  logic [31:0] s1_spd2, s1_lim2;
  logic signed [34:0] s1_bandoff;
  logic [1:0] s1_kind;
  logic s1_up, s1_gt, s1_le_adv;
  logic signed [16:0] s1_dband, s1_dfull;
  logic [15:0] s1_wacc, s1_wjerk, s1_ajerk;
  logic [31:0] s1_parent;

  logic [16:0] spd_lo;
  logic [31:0] p_low, p_main;
  logic signed [16:0] a17, adv17, hard17;
  logic up;
  always_comb begin
    a17 = 17'(node.accel);
    up = !node.accel[15];
    adv17 = up ? $signed({1'b0, accel_bounds[15:0]}) : 17'(signed'(decel_bounds[15:0]));
    hard17 = up ? $signed({1'b0, accel_bounds[31:16]})
                : 17'(signed'(decel_bounds[31:16]));
    spd_lo = (node.speed < min_speed) ? 17'(min_speed - node.speed) : '0;
    p_low = speed_weights[31:16] * spd_lo[15:0];
    if (node.limit_speed <= 16'd1) p_main = speed_weights[47:32] * node.speed;
    else if (node.speed > node.limit_speed)
      p_main = speed_weights[47:32] * (node.speed - node.limit_speed);
    else p_main = speed_weights[15:0] * (node.limit_speed - node.speed);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_stop <= (node.at_rest && node.position < goal_distance)
                 ? (goal_distance - node.position) * stop_weight : '0;
      s1_q18 <= 34'(p_main) + ((node.limit_speed <= 16'd1) ? 34'd0 : 34'(p_low));
      s1_spd2 <= node.speed * node.speed;
      s1_lim2 <= node.limit_speed * node.limit_speed;
      s1_bandoff <= (35'(adv17) * 35'(signed'({1'b0, step_length}))) <<< 1;
      s1_up <= up;
      if (a17 >= -17'sd40 && a17 <= 17'sd40) s1_kind <= KIND_ZERO;
      else if (up ? (a17 > hard17) : (a17 < hard17)) s1_kind <= KIND_HARD;
      else s1_kind <= KIND_BAND;
      s1_gt <= node.speed > node.limit_speed;
      s1_le_adv <= a17 <= adv17;
      s1_dband <= a17 - adv17;
      s1_dfull <= a17;
      s1_wacc <= up ? motion_weights[47:32] : motion_weights[31:16];
      s1_wjerk <= motion_weights[15:0];
      s1_ajerk <= node.jerk_value[15] ? 16'(-node.jerk_value) : node.jerk_value;
      s1_parent <= node.prior_cost;
    end
  end

  // stage 2: choose diff, square it and jerk
  logic signed [34:0] edge2;
  logic below;
  logic signed [16:0] diff;
  logic [16:0] adiff;
  always_comb begin
    edge2 = s1_up ? 35'(s1_lim2) - 35'(s1_bandoff) : 35'(s1_lim2) + 35'(s1_bandoff);
    if (edge2 < 0) edge2 = '0;
    below = $signed({3'b0, s1_spd2}) < edge2;
    if (below) diff = s1_dband;
    else if (s1_gt) diff = s1_dfull;
    else if (s1_up) diff = s1_le_adv ? '0 : s1_dband;
    else diff = !s1_le_adv ? '0 : s1_dband;
    adiff = diff[16] ? 17'(-diff) : 17'(diff);
  end

  logic [31:0] s2_stop, s2_lim, s2_parent;
  logic [33:0] s2_d2;
  logic [31:0] s2_j2;
  logic [1:0] s2_kind;
  logic [15:0] s2_wacc, s2_wjerk;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_stop <= sat32(48'(s1_stop));
      s2_lim <= sat32(48'(s1_q18 >> 2));
      s2_d2 <= adiff * adiff;
      s2_j2 <= s1_ajerk * s1_ajerk;
      s2_kind <= s1_kind; s2_wacc <= s1_wacc; s2_wjerk <= s1_wjerk;
      s2_parent <= s1_parent;
    end
  end

  // stage 3: weight products
  logic [31:0] s3_stop, s3_lim, s3_acc, s3_jerk, s3_parent;
  logic [49:0] pa;
  logic [47:0] pj;
  always_comb begin
    pa = s2_wacc * s2_d2;
    pj = s2_wjerk * s2_j2;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_stop <= s2_stop; s3_lim <= s2_lim; s3_parent <= s2_parent;
      case (s2_kind)
        KIND_ZERO: s3_acc <= '0;
        KIND_HARD: s3_acc <= HARD_COST;
        default: s3_acc <= (|pa[49:48]) ? SAT : pa[47:16];
      endcase
      s3_jerk <= (|pj[47:44]) ? SAT : pj[43:12];
    end
  end

  // stage 4: sum
  logic [34:0] total;
  assign total = 35'(s3_stop) + 35'(s3_lim) + 35'(s3_acc) + 35'(s3_jerk) + 35'(s3_parent);
  always_ff @(posedge clk) begin
    if (adv) begin
      cost.stop_cost <= s3_stop;
      cost.limit_cost <= s3_lim;
      cost.accel_cost <= s3_acc;
      cost.jerk_cost_out <= s3_jerk;
      cost.sum_cost <= (|total[34:32]) ? SAT : total[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[2:0], acc_in};
  end
  assign cost.valid = vld[3];

  `SPNC_ASSERT(a_sum_ge, cost.valid |-> cost.sum_cost >= cost.stop_cost, "sum below stop")
  `SPNC_ASSERT(a_hold, (cost.valid && !cost.ready) |=> $stable(vld), "pipeline moved in stall")
  `SPNC_ASSERT(a_rdy, (cost.valid && !cost.ready) |-> !node.ready, "ready while stalled")
  `SPNC_ASSERT_RST(a_rst, rst |=> vld == '0, "valid after reset")
endmodule
`default_nettype wire

// ===== tb/sv/tb_speed_profile_node_cost_core.sv =====
// ----------------------------------------------------------------------------
// Speed profile node cost core testbench
// Drives node items through the valid/ready channel with random bursts and
// output stalls, predicts every cost term from the register settings and
// compares each cost item field by field in order.
// ----------------------------------------------------------------------------
module tb_speed_profile_node_cost_core;
  timeunit 1ns;
  timeprecision 1ps;
  import spnc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  spnc_in_if node ();
  spnc_out_if cost ();

  speed_profile_node_cost_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .node(node.sink), .cost(cost.source)
  );

  always #5 clk = ~clk;

  logic [23:0] goal_dist;
  logic [15:0] step_len;
  logic [15:0] min_spd;
  logic [31:0] acc_bnd;
  logic [31:0] dec_bnd;
  logic [47:0] mot_w;
  logic [47:0] spd_w;
  logic [15:0] stop_w;

  in_item_t pending_nodes[$];
  out_item_t expected_costs[$];
  int mismatches = 0;
  bit hold_sender = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_cnt = 0;

  function automatic logic [31:0] sat(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] band_term(input longint a, input longint adv,
                                            input bit up, input longint spd,
                                            input longint lim, input longint w);
    longint edge2, diff, d;
    edge2 = lim * lim + (up ? -2 : 2) * adv * longint'(step_len);
    if (edge2 < 0) edge2 = 0;
    if (spd * spd < edge2) diff = a - adv;
    else if (spd > lim) diff = a;
    else if (up) diff = (a <= adv) ? 0 : a - adv;
    else diff = (a > adv) ? 0 : a - adv;
    d = diff < 0 ? -diff : diff;
    return sat(64'(w * d * d) >> 16);
  endfunction

  function automatic out_item_t node_costs(input in_item_t n);
    out_item_t r;
    longint spd, lim, acc, aj, q18, wo, wl, wg;
    logic [63:0] total;
    spd = n.speed;
    lim = n.limit_speed;
    acc = n.accel;
    wo = spd_w[47:32];
    wl = spd_w[31:16];
    wg = spd_w[15:0];
    r.stop_cost = (n.at_rest && n.position < goal_dist) ?
                  sat(64'(goal_dist - n.position) * stop_w) : 32'd0;
    q18 = 0;
    if (lim <= 1) begin
      q18 = wo * spd;
    end else begin
      if (spd < min_spd) q18 += wl * (longint'(min_spd) - spd);
      if (spd > lim) q18 += wo * (spd - lim);
      else if (spd < lim) q18 += wg * (lim - spd);
    end
    r.limit_cost = sat(64'(q18) >> 2);
    if (acc >= -SmallAccel && acc <= SmallAccel) begin
      r.accel_cost = 0;
    end else if (acc < 0) begin
      r.accel_cost = (acc < longint'($signed(dec_bnd[31:16]))) ? HARD_COST :
        band_term(acc, longint'($signed(dec_bnd[15:0])), 1'b0, spd, lim, mot_w[31:16]);
    end else begin
      r.accel_cost = (acc > longint'(acc_bnd[31:16])) ? HARD_COST :
        band_term(acc, longint'(acc_bnd[15:0]), 1'b1, spd, lim, mot_w[47:32]);
    end
    aj = n.jerk_value;
    if (aj < 0) aj = -aj;
    r.jerk_cost_out = sat(64'(longint'(mot_w[15:0]) * aj * aj) >> 12);
    total = 64'(r.stop_cost) + r.limit_cost + r.accel_cost + r.jerk_cost_out
            + n.prior_cost;
    r.sum_cost = sat(total);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      node.valid <= 1'b0;
    end else begin
      if (node.valid && node.ready) void'(pending_nodes.pop_front());
      if (node.valid && !node.ready) begin
        node.valid <= 1'b1;
      end else if (gap_left > 0 || hold_sender || pending_nodes.size() == 0) begin
        node.valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_item_t n;
        n = pending_nodes[0];
        expected_costs.push_back(node_costs(n));
        node.valid <= 1'b1;
        node.position <= n.position;
        node.speed <= n.speed;
        node.accel <= n.accel;
        node.jerk_value <= n.jerk_value;
        node.limit_speed <= n.limit_speed;
        node.at_rest <= n.at_rest;
        node.prior_cost <= n.prior_cost;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cost.ready <= 1'b0;
    end else begin
      if (cost.valid && cost.ready) begin
        if (expected_costs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected cost item at %0t", $realtime);
        end else begin
          out_item_t e;
          out_item_t a;
          e = expected_costs.pop_front();
          a = '{cost.stop_cost, cost.limit_cost, cost.accel_cost,
                cost.jerk_cost_out, cost.sum_cost};
          if (a !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h %h %h got %h %h %h %h %h",
                       e.stop_cost, e.limit_cost, e.accel_cost, e.jerk_cost_out,
                       e.sum_cost, a.stop_cost, a.limit_cost, a.accel_cost,
                       a.jerk_cost_out, a.sum_cost);
          end
        end
      end
      if (stall_cnt == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_cnt <= $urandom_range(5, 40);
      end else begin
        stall_cnt <= stall_cnt - 1;
      end
      case (stall_mode)
        0: cost.ready <= 1'b1;
        1: cost.ready <= 1'($urandom_range(0, 1));
        2: cost.ready <= ($urandom_range(0, 4) != 0);
        default: cost.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin
    node.position = '0;
    node.speed = '0;
    node.accel = '0;
    node.jerk_value = '0;
    node.limit_speed = '0;
    node.at_rest = 1'b0;
    node.prior_cost = '0;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_GOAL: goal_dist = val[23:0];
      REG_STEP: step_len = val[15:0];
      REG_MINSPD: min_spd = val[15:0];
      REG_ACCB: acc_bnd = val[31:0];
      REG_DECB: dec_bnd = val[31:0];
      REG_MOTW: mot_w = val;
      REG_SPDW: spd_w = val;
      default: stop_w = val[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_nodes.size() != 0 || expected_costs.size() != 0 || node.valid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic setup(input int mode);
    logic [47:0] r48;
    r48 = 48'({$urandom, $urandom});
    case (mode)
      0: begin
        write_reg(REG_GOAL, 48'(24'hFFFFFF)); write_reg(REG_STEP, 48'(16'hFFFF));
        write_reg(REG_MINSPD, 48'(16'hFFFF)); write_reg(REG_ACCB, 48'(32'hFFFF_FFFF));
        write_reg(REG_DECB, 48'(32'h8000_8000)); write_reg(REG_MOTW, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_SPDW, 48'hFFFF_FFFF_FFFF); write_reg(REG_STOPW, 48'(16'hFFFF));
      end
      1: begin
        write_reg(REG_GOAL, '0); write_reg(REG_STEP, '0); write_reg(REG_MINSPD, '0);
        write_reg(REG_ACCB, '0); write_reg(REG_DECB, 48'(32'h7FFF_7FFF));
        write_reg(REG_MOTW, '0); write_reg(REG_SPDW, '0); write_reg(REG_STOPW, '0);
      end
      default: begin
        write_reg(REG_GOAL, 48'($urandom_range(0, 24'hFFFFFF)));
        write_reg(REG_STEP, 48'($urandom_range(0, 1024)));
        write_reg(REG_MINSPD, 48'($urandom_range(0, 16'hFFFF)));
        write_reg(REG_ACCB, 48'({16'($urandom_range(2000, 16000)),
                                 16'($urandom_range(200, 8000))}));
        write_reg(REG_DECB, 48'({16'(-$urandom_range(2000, 20000)),
                                 16'(-$urandom_range(200, 8000))}));
        write_reg(REG_MOTW, (mode == 2) ? r48 :
                  {16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                   16'($urandom_range(0, 1024))});
        write_reg(REG_SPDW, 48'({$urandom, $urandom}));
        write_reg(REG_STOPW, 48'($urandom));
      end
    endcase
  endtask

  function automatic in_item_t rand_node();
    in_item_t n;
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    n = in_item_t'(r[$bits(in_item_t)-1:0]);
    case ($urandom_range(0, 5))
      0: n.accel = 16'($urandom_range(0, 80) - 40);
      1: n.limit_speed = 16'($urandom_range(0, 1));
      2: n.speed = n.limit_speed;
      3: begin
        n.speed = 16'($urandom_range(0, 8192));
        n.limit_speed = 16'($urandom_range(2, 8192));
        n.accel = 16'($urandom_range(0, 24000) - 12000);
        n.jerk_value = 16'($urandom_range(0, 4000) - 2000);
        n.prior_cost = $urandom_range(0, 32'h00FF_FFFF);
      end
      default: ;
    endcase
    return n;
  endfunction

  initial begin
    in_item_t n;
    goal_dist = 0; step_len = 256; min_spd = 0; acc_bnd = 0;
    dec_bnd = 0; mot_w = 0; spd_w = 0; stop_w = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    setup(0);
    n = '0;
    pending_nodes.push_back(n);
    n = '{24'hFFFFFF, 16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF};
    pending_nodes.push_back(n);
    n = '{24'h0, 16'h0, -16'sh8000, -16'sh8000, 16'h1, 1'b1, 32'h0};
    pending_nodes.push_back(n);
    n = '{24'h10, 16'h100, 16'sd40, 16'sd3, 16'h0, 1'b0, 32'h1};
    pending_nodes.push_back(n);
    n = '{24'h10, 16'h100, -16'sd41, 16'sd3, 16'h200, 1'b1, 32'h1};
    pending_nodes.push_back(n);
    n = '{24'h10, 16'h300, 16'sd41, -16'sd1, 16'h200, 1'b1, 32'h1};
    pending_nodes.push_back(n);
    for (int i = 0; i < 10; i++) pending_nodes.push_back(rand_node());
    drain();
    setup(1);
    for (int i = 0; i < 8; i++) pending_nodes.push_back(rand_node());
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      setup(2 + ph % 2);
      for (int i = 0; i < 250; i++) pending_nodes.push_back(rand_node());
      if (ph == 3) begin
        while (pending_nodes.size() > 120) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_costs.size() != 0 || node.valid) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end
    if (mismatches == 0 && expected_costs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
